[sv/rwmf_pkg.sv]
// rwmf_pkg: shared constants, types and control struct for the window median filter
// no dependencies; imported by the interfaces, rwmf_rank_unit and the top level
`default_nettype none

package rwmf_pkg;

    // frame limits
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_RADIUS  = 10;

    // line store holds 2r rows plus 2r+1 pixels at the largest size
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int RADIUS_W    = 4;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int SIDE_W      = 5;
    localparam int WIN_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W       = $clog2(WIN_MAX + 1);
    localparam int BIT_W       = $clog2(SAMPLE_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 2'd3;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // three color samples of one pixel
    typedef struct packed {
        sample_t blue;
        sample_t green;
        sample_t red;
    } rgb_t;

    // sequencer to rank unit control
    typedef struct packed {
        logic             start;
        logic             count_en;
        logic             step;
        logic [BIT_W-1:0] bitpos;
    } rank_ctrl_t;

endpackage

`default_nettype wire

[sv/rwmf_ifs.sv]
// rwmf_ifs: pixel request, result and configuration channel interfaces
// depends on rwmf_pkg
`default_nettype none

interface rwmf_in_if
    import rwmf_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    drain;
    sample_t red_in;
    sample_t green_in;
    sample_t blue_in;
    sample_t alpha_in;

    modport source (output valid, drain, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, drain, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rwmf_out_if
    import rwmf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t red_out;
    sample_t green_out;
    sample_t blue_out;
    sample_t alpha_out;
    logic    frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    output ready);
endinterface

interface rwmf_cfg_if
    import rwmf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/rwmf_rank_unit.sv]
// rwmf_rank_unit: bit-serial rank selection for red, green and blue in parallel
// depends on rwmf_pkg; driven by the sweep sequencer in the top level
`default_nettype none

module rwmf_rank_unit
    import rwmf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rank_ctrl_t       ctrl,
    input  wire logic [CNT_W-1:0] half,
    input  wire rgb_t             sample,
    output rgb_t                  median
);

    sample_t          prefix_reg [3];
    logic [CNT_W-1:0] rank_reg   [3];
    logic [CNT_W-1:0] count_reg  [3];
    sample_t          hi_mask;
    sample_t          bit_mask;
    sample_t          chan       [3];
    logic             hit        [3];

    // bits above the current position and the current bit itself
    always_comb
    begin
        hi_mask  = sample_t'({SAMPLE_W{1'b1}} << ({1'b0, ctrl.bitpos} + 5'd1));
        bit_mask = sample_t'(1) << ctrl.bitpos;
        chan[0]  = sample.red;
        chan[1]  = sample.green;
        chan[2]  = sample.blue;
        for (int c = 0; c < 3; c++)
        begin
            hit[c] = (((chan[c] ^ prefix_reg[c]) & hi_mask) == '0) &&
                     ((chan[c] & bit_mask) == '0);
        end
    end

    // count, then settle one bit of each channel per pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prefix_reg[c] <= '0;
                rank_reg[c]   <= '0;
                count_reg[c]  <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (ctrl.start)
                begin
                    prefix_reg[c] <= '0;
                    rank_reg[c]   <= half;
                    count_reg[c]  <= '0;
                end
                else if (ctrl.step)
                begin
                    if (rank_reg[c] >= count_reg[c])
                    begin
                        rank_reg[c]   <= rank_reg[c] - count_reg[c];
                        prefix_reg[c] <= prefix_reg[c] | bit_mask;
                    end
                    count_reg[c] <= '0;
                end
                else if (ctrl.count_en && hit[c])
                begin
                    count_reg[c] <= count_reg[c] + CNT_W'(1);
                end
            end
        end
    end

    assign median.red   = prefix_reg[0];
    assign median.green = prefix_reg[1];
    assign median.blue  = prefix_reg[2];

endmodule

`default_nettype wire

[sv/rgb_window_median_filter_top.sv]
// rgb_window_median_filter_top: line store, frame counters and window sweep sequencer
// depends on rwmf_pkg, rwmf_ifs and rwmf_rank_unit
//
//  channel   dir   payload                                         handshake
//  in_ch     in    drain, red_in, green_in, blue_in, alpha_in      valid/ready
//  out_ch    out   red_out, green_out, blue_out, alpha_out,         valid/ready
//                  frame_end
//  cfg_ch    in    index, data (image_width, image_height, radius)  valid/ready
//
// a border result steps through emit, store read, store data and push; an interior
// result is set by one line store read port swept over the n = (2r+1)^2 window once
// per median bit (all three colors are counted on the same read).
// reset needs no clearing pass: every store read falls on a pixel of the current frame.
// one request is in work at a time; a held result stalls only the final push.
`default_nettype none

module rgb_window_median_filter_top
    import rwmf_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    rwmf_in_if.sink    in_ch,
    rwmf_out_if.source out_ch,
    rwmf_cfg_if.sink   cfg_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMIT  = 3'd1;
    localparam logic [2:0] S_CREAD = 3'd2;
    localparam logic [2:0] S_CDATA = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_LAST  = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W+1)'(STORE_DEPTH);
    localparam int CNT_IN_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int LAG_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    logic [63:0] store [STORE_DEPTH];
    logic [63:0] mem_q_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [2:0] state_reg, state_next;

    logic [WIDTH_W-1:0]  w_reg;
    logic [HEIGHT_W-1:0] h_reg;
    logic [RADIUS_W-1:0] r_reg;

    logic [COL_W-1:0]    in_col_reg, out_col_reg;
    logic [ROW_W-1:0]    in_row_reg, out_row_reg;
    logic [CNT_IN_W-1:0] in_count_reg;
    logic [ADDR_W-1:0]   in_addr_reg, out_addr_reg;
    logic                in_done_reg;

    logic [ADDR_W-1:0] tl_reg, row_addr_reg, col_addr_reg;
    logic [SIDE_W-1:0] i_reg, j_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              rd_v_reg;
    logic              interior_reg, last_reg;
    logic [63:0]       border_reg;

    logic              out_valid_reg;
    rgb_t              out_rgb_reg;
    sample_t           out_alpha_reg;
    logic              out_end_reg;

    logic [SIDE_W-1:0] side;
    logic [CNT_W-1:0]  half;
    logic [LAG_W-1:0]  lag;
    logic [ADDR_W:0]   tl_calc, row_step, col_step;
    logic              interior, is_last;
    logic              in_fire, cfg_fire, push;
    rank_ctrl_t        ctrl;
    rgb_t              median;
    rgb_t              sample;

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + (ADDR_W+1)'(1);
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[ADDR_W-1:0];
    endfunction

    // window geometry from the registers
    always_comb
    begin
        side = {r_reg, 1'b1};
        half = CNT_W'((10'(side) * 10'(side)) >> 1);
        lag  = LAG_W'(15'(r_reg) * 15'(w_reg) + 15'(r_reg));
    end

    // top-left of the window and row/column stepping, all modulo the store depth
    always_comb
    begin
        if ({1'b0, out_addr_reg} >= (ADDR_W+1)'(lag))
        begin
            tl_calc = {1'b0, out_addr_reg} - (ADDR_W+1)'(lag);
        end
        else
        begin
            tl_calc = {1'b0, out_addr_reg} + DEPTH_X - (ADDR_W+1)'(lag);
        end
        row_step = {1'b0, row_addr_reg} + (ADDR_W+1)'(w_reg);
        if (row_step >= DEPTH_X)
        begin
            row_step = row_step - DEPTH_X;
        end
        col_step = (ADDR_W+1)'(addr_inc(col_addr_reg));
    end

    // position of the pending output
    always_comb
    begin
        interior = (out_row_reg >= ROW_W'(r_reg)) &&
                   ((HEIGHT_W'(out_row_reg) + HEIGHT_W'(r_reg)) < h_reg) &&
                   (out_col_reg >= COL_W'(r_reg)) &&
                   ((WIDTH_W'(out_col_reg) + WIDTH_W'(r_reg)) < w_reg);
        is_last  = (HEIGHT_W'(out_row_reg) == h_reg - HEIGHT_W'(1)) &&
                   (WIDTH_W'(out_col_reg) == w_reg - WIDTH_W'(1));
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign in_fire      = in_ch.valid && (state_reg == S_IDLE);
    assign cfg_fire     = cfg_ch.valid;
    assign push         = (state_reg == S_PUSH) && (!out_valid_reg || out_ch.ready);

    // line store: one write port for incoming pixels, one registered read port
    assign rd_addr = (state_reg == S_CREAD) ? out_addr_reg : col_addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && !in_ch.drain && !in_done_reg)
        begin
            store[in_addr_reg] <= {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in,
                                   in_ch.red_in};
        end
        mem_q_reg <= store[rd_addr];
    end

    assign sample = rgb_t'(mem_q_reg[47:0]);

    // rank unit control
    always_comb
    begin
        ctrl.start    = (state_reg == S_EMIT) && interior;
        ctrl.count_en = rd_v_reg;
        ctrl.step     = (state_reg == S_STEP);
        ctrl.bitpos   = bit_reg;
    end

    rwmf_rank_unit u_rank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .half   (half),
        .sample (sample),
        .median (median)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.drain)
                    begin
                        if (in_done_reg)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (!in_done_reg && (in_count_reg >= CNT_IN_W'(lag)))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:  state_next = interior ? S_SWEEP : S_CREAD;
            S_CREAD: state_next = S_CDATA;
            S_CDATA: state_next = S_PUSH;
            S_SWEEP:
            begin
                if ((j_reg == side - SIDE_W'(1)) && (i_reg == side - SIDE_W'(1)))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:  state_next = S_STEP;
            S_STEP:  state_next = (bit_reg == '0) ? S_PUSH : S_SWEEP;
            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            w_reg         <= WIDTH_W'(MAX_WIDTH);
            h_reg         <= HEIGHT_W'(1024);
            r_reg         <= RADIUS_W'(1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_count_reg  <= '0;
            in_addr_reg   <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_addr_reg  <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            tl_reg        <= '0;
            row_addr_reg  <= '0;
            col_addr_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            bit_reg       <= '0;
            interior_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == S_SWEEP);

            // result register
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // pixel intake counters
            if (in_fire && !in_ch.drain && !in_done_reg)
            begin
                in_count_reg <= in_count_reg + CNT_IN_W'(1);
                in_addr_reg  <= addr_inc(in_addr_reg);
                if ((WIDTH_W'(in_col_reg) + WIDTH_W'(1)) >= w_reg)
                begin
                    in_col_reg <= '0;
                    if ((HEIGHT_W'(in_row_reg) + HEIGHT_W'(1)) >= h_reg)
                    begin
                        in_done_reg <= 1'b1;
                    end
                    else
                    begin
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end

            // window sweep setup and stepping
            if (state_reg == S_EMIT)
            begin
                interior_reg <= interior;
                last_reg     <= is_last;
                tl_reg       <= tl_calc[ADDR_W-1:0];
                row_addr_reg <= tl_calc[ADDR_W-1:0];
                col_addr_reg <= tl_calc[ADDR_W-1:0];
                i_reg        <= '0;
                j_reg        <= '0;
                bit_reg      <= BIT_W'(SAMPLE_W - 1);
            end
            else if (state_reg == S_SWEEP)
            begin
                if (j_reg == side - SIDE_W'(1))
                begin
                    j_reg        <= '0;
                    i_reg        <= i_reg + SIDE_W'(1);
                    row_addr_reg <= row_step[ADDR_W-1:0];
                    col_addr_reg <= row_step[ADDR_W-1:0];
                end
                else
                begin
                    j_reg        <= j_reg + SIDE_W'(1);
                    col_addr_reg <= col_step[ADDR_W-1:0];
                end
            end
            else if ((state_reg == S_STEP) && (bit_reg != '0))
            begin
                bit_reg      <= bit_reg - BIT_W'(1);
                row_addr_reg <= tl_reg;
                col_addr_reg <= tl_reg;
                i_reg        <= '0;
                j_reg        <= '0;
            end

            // output position advance, frame restart after the last pixel
            if (push)
            begin
                if (last_reg)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_count_reg <= '0;
                    in_addr_reg  <= '0;
                    in_done_reg  <= 1'b0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_addr_reg <= '0;
                end
                else
                begin
                    out_addr_reg <= addr_inc(out_addr_reg);
                    if ((WIDTH_W'(out_col_reg) + WIDTH_W'(1)) >= w_reg)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
            end

            // a write to width, height or radius clamps the value and restarts the frame
            if (cfg_fire)
            begin
                unique case (cfg_ch.index)
                    REG_IMAGE_WIDTH:
                    begin
                        if (cfg_ch.data[WIDTH_W-1:0] == '0)
                            w_reg <= WIDTH_W'(1);
                        else if (cfg_ch.data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH))
                            w_reg <= WIDTH_W'(MAX_WIDTH);
                        else
                            w_reg <= cfg_ch.data[WIDTH_W-1:0];
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        if (cfg_ch.data == '0)
                            h_reg <= HEIGHT_W'(1);
                        else if (cfg_ch.data > HEIGHT_W'(MAX_HEIGHT))
                            h_reg <= HEIGHT_W'(MAX_HEIGHT);
                        else
                            h_reg <= cfg_ch.data;
                    end
                    REG_RADIUS:
                    begin
                        if (cfg_ch.data[RADIUS_W-1:0] == '0)
                            r_reg <= RADIUS_W'(1);
                        else if (cfg_ch.data[RADIUS_W-1:0] > RADIUS_W'(MAX_RADIUS))
                            r_reg <= RADIUS_W'(MAX_RADIUS);
                        else
                            r_reg <= cfg_ch.data[RADIUS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                if (cfg_ch.index != REG_UNUSED)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_count_reg <= '0;
                    in_addr_reg  <= '0;
                    in_done_reg  <= 1'b0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_addr_reg <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CDATA)
        begin
            border_reg <= mem_q_reg;
        end
        if (push)
        begin
            out_end_reg <= last_reg;
            if (interior_reg)
            begin
                out_rgb_reg   <= median;
                out_alpha_reg <= FULL_SCALE;
            end
            else
            begin
                out_rgb_reg   <= rgb_t'(border_reg[47:0]);
                out_alpha_reg <= border_reg[63:48];
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.red_out   = out_rgb_reg.red;
    assign out_ch.green_out = out_rgb_reg.green;
    assign out_ch.blue_out  = out_rgb_reg.blue;
    assign out_ch.alpha_out = out_alpha_reg;
    assign out_ch.frame_end = out_end_reg;

endmodule

`default_nettype wire

[tb/rgb_window_median_filter_top_tb.sv]
// rgb_window_median_filter_top_tb: self-checking bench for the window median filter
// depends on rwmf_pkg, rwmf_ifs and rgb_window_median_filter_top
// predicts every result in the bench and compares it with the block's output stream
`timescale 1ns / 1ps

module rgb_window_median_filter_top_tb;
    import rwmf_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int LONG_HOLD   = 3000;

    typedef struct {
        sample_t red;
        sample_t green;
        sample_t blue;
        sample_t alpha;
        logic    frame_end;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    rwmf_in_if  in_ch ();
    rwmf_out_if out_ch ();
    rwmf_cfg_if cfg_ch ();

    rgb_window_median_filter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // predictor state
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [63:0]         pixel_store [STORE_DEPTH];
    int                  in_col, in_row, out_col, out_row;
    bit                  frame_loaded;

    pixel_result_t filtered_q [$];
    int            errors;
    int            cycles;
    bit            idle_on;
    bit            send_idle_on;
    int            hold_cycles;
    int            sink_burst;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int eff_width();
        return (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 :
               (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic int eff_radius();
        return (radius_reg == 0) ? 1 :
               (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    endfunction

    // cycles for one interior result plus margin
    function automatic int settle_cycles();
        int side;
        side = 2 * eff_radius() + 1;
        return 16 * (side * side + 3) + 40;
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_loaded = 0;
    endfunction

    // median of one channel over the window, by sorting
    function automatic sample_t window_median(int p, int w, int r, int ch);
        sample_t vals [441];
        sample_t t;
        int n, k, base;
        n = 0;
        base = p - r * w - r;
        for (int i = 0; i < 2 * r + 1; i++)
            for (int j = 0; j < 2 * r + 1; j++)
            begin
                vals[n] = pixel_store[(base + i * w + j) % STORE_DEPTH][16*ch +: 16];
                n++;
            end
        for (int i = 1; i < n; i++)
        begin
            t = vals[i];
            k = i - 1;
            while (k >= 0 && vals[k] > t)
            begin
                vals[k+1] = vals[k];
                k--;
            end
            vals[k+1] = t;
        end
        return vals[n/2];
    endfunction

    function automatic void emit_result();
        int w, h, r, p;
        logic [63:0] centre;
        pixel_result_t res;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        p = out_row * w + out_col;
        centre = pixel_store[p % STORE_DEPTH];
        if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w)
        begin
            res.red   = window_median(p, w, r, 0);
            res.green = window_median(p, w, r, 1);
            res.blue  = window_median(p, w, r, 2);
            res.alpha = FULL_SCALE;
        end
        else
        begin
            res.red   = centre[15:0];
            res.green = centre[31:16];
            res.blue  = centre[47:32];
            res.alpha = centre[63:48];
        end
        res.frame_end = (p == w * h - 1);
        filtered_q.push_back(res);
        if (res.frame_end)
            restart_frame();
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endfunction

    // predictor step for one accepted request
    function automatic void model_request(logic drain, logic [63:0] px);
        int w, h, q;
        w = eff_width();
        h = eff_height();
        if (drain)
        begin
            if (frame_loaded)
                emit_result();
            return;
        end
        if (frame_loaded)
            return;
        q = in_row * w + in_col;
        pixel_store[q % STORE_DEPTH] = px;
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            if (in_row + 1 >= h)
                frame_loaded = 1;
            else
                in_row++;
        end
        else
            in_col++;
        if (q >= eff_radius() * w + eff_radius())
            emit_result();
    endfunction

    // result sink: ready with random stall bursts and a long hold when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            if (idle_on && sink_burst == 0 && $urandom_range(0, 5) == 0)
                sink_burst = $urandom_range(1, 19);
            out_ch.ready = (sink_burst == 0);
            if (sink_burst > 0)
                sink_burst--;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        pixel_result_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (filtered_q.size() == 0)
            begin
                $display("%0t: unexpected result r=%h g=%h b=%h a=%h fe=%b", $time,
                         out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                         out_ch.alpha_out, out_ch.frame_end);
                errors++;
            end
            else
            begin
                exp_res = filtered_q.pop_front();
                if (out_ch.red_out !== exp_res.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, exp_res.red,
                             out_ch.red_out);
                    errors++;
                end
                if (out_ch.green_out !== exp_res.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, exp_res.green,
                             out_ch.green_out);
                    errors++;
                end
                if (out_ch.blue_out !== exp_res.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, exp_res.blue,
                             out_ch.blue_out);
                    errors++;
                end
                if (out_ch.alpha_out !== exp_res.alpha)
                begin
                    $display("%0t: alpha expected %h actual %h", $time, exp_res.alpha,
                             out_ch.alpha_out);
                    errors++;
                end
                if (out_ch.frame_end !== exp_res.frame_end)
                begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             exp_res.frame_end, out_ch.frame_end);
                    errors++;
                end
            end
        end
    end

    // send one pixel request; entered and left at a falling edge
    task automatic send_request(input logic drain, input logic [63:0] px);
        if (send_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.drain    = drain;
        in_ch.red_in   = px[15:0];
        in_ch.green_in = px[31:16];
        in_ch.blue_in  = px[47:32];
        in_ch.alpha_in = px[63:48];
        do @(posedge clk); while (!in_ch.ready);
        model_request(drain, px);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = val[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_W-1:0];
            REG_RADIUS:       radius_reg = val[RADIUS_W-1:0];
            default:          ;
        endcase
        if (idx != REG_UNUSED)
            restart_frame();
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // wait until every predicted result is out and the block has gone quiet
    task automatic settle();
        while (filtered_q.size() != 0)
            @(negedge clk);
        repeat (settle_cycles()) @(negedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input int r);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_RADIUS, CFG_DATA_W'(r));
    endtask

    function automatic logic [63:0] gen_pixel(int mode);
        logic [63:0] px;
        for (int c = 0; c < 4; c++)
            px[16*c +: 16] = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 3) * 21845);
        return px;
    endfunction

    // feed pixels, drain if stop_after < 0 till frame end; noise adds ignored requests
    task automatic feed_frame(input int mode, input int noise, input int stop_after);
        int sent;
        sent = 0;
        while (!frame_loaded && sent != stop_after)
        begin
            if (noise && $urandom_range(0, 29) == 0)
                send_request(1'b1, gen_pixel(0));
            send_request(1'b0, gen_pixel(mode));
            sent++;
        end
        while (frame_loaded && stop_after < 0)
        begin
            if (noise && $urandom_range(0, 29) == 0)
                send_request(1'b0, gen_pixel(0));
            send_request(1'b1, gen_pixel(0));
        end
    endtask

    task automatic test_extremes();
        logic [63:0] corners [9];
        corners = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_5555_AAAA_5555,
                    64'h5555_AAAA_5555_AAAA, 64'h8000_0001_7FFF_FFFE, 64'h1,
                    64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF, 64'h1234_8765_FEDC_0F0F};
        set_frame(3, 3, 1);
        foreach (corners[i])
            send_request(1'b0, corners[i]);
        while (frame_loaded)
            send_request(1'b1, 64'h0);
        set_frame(5, 4, 1);
        feed_frame(1, 0, -1);
    endtask

    task automatic test_ignored_requests();
        // drain while the frame is still loading, pixel while draining
        set_frame(4, 3, 1);
        send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        repeat (12) send_request(1'b0, gen_pixel(0));
        send_request(1'b0, gen_pixel(0));
        send_request(1'b1, 64'h0);
        send_request(1'b0, gen_pixel(0));
        while (frame_loaded)
            send_request(1'b1, 64'h0);
        // tiny images with no interior, and a write to the unused index
        set_frame(1, 1, 1);
        write_reg(REG_UNUSED, 13'h1FFF);
        feed_frame(0, 0, -1);
        set_frame(2, 5, 2);
        feed_frame(0, 0, -1);
    endtask

    // out of range register values, partial frames to keep the item count down
    task automatic test_clamped_sizes();
        set_frame(2047, 0, 0);
        feed_frame(0, 0, 40);
        set_frame(0, 8191, 15);
        feed_frame(0, 0, 60);
    endtask

    task automatic test_largest_window();
        set_frame(22, 21, 10);
        feed_frame(1, 0, -1);
    endtask

    task automatic test_restart();
        set_frame(9, 7, 2);
        feed_frame(0, 0, 30);
        set_frame(6, 6, 1);
        feed_frame(0, 0, -1);
    endtask

    task automatic test_backpressure();
        set_frame(16, 6, 1);
        hold_cycles = LONG_HOLD;
        feed_frame(0, 0, -1);
    endtask

    task automatic test_random_frames(input int budget);
        int sent_before;
        int w, h, r;
        sent_before = 0;
        while (sent_before < budget)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 9);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 2);
            set_frame(w, h, r);
            if ($urandom_range(0, 19) == 0)
                feed_frame($urandom_range(0, 1), 1, $urandom_range(1, w * h));
            else
                feed_frame($urandom_range(0, 1), 1, -1);
            sent_before += 2 * w * h;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        idle_on = 1'b1;
        send_idle_on = 1'b1;
        hold_cycles = 0;
        sink_burst = 0;
        in_ch.valid = 1'b0;
        in_ch.drain = 1'b0;
        in_ch.red_in = '0;
        in_ch.green_in = '0;
        in_ch.blue_in = '0;
        in_ch.alpha_in = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        radius_reg = 4'd1;
        restart_frame();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_ignored_requests();
        test_clamped_sizes();
        test_largest_window();
        test_restart();
        test_backpressure();
        test_random_frames(80);
        // last stretch with no idling on either side
        idle_on = 1'b0;
        send_idle_on = 1'b0;
        test_random_frames(40);

        settle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
